### sv/uref_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// uref_pkg
// Shared types and constants for the UART receive status event ring.
// ============================================================================
package uref_pkg;

   localparam int RX_W   = 12;
   localparam int DATA_W = 8;
   localparam int CSR_W  = 9;

   localparam int BIT_FRAMING = 8;
   localparam int BIT_PARITY  = 9;
   localparam int BIT_OVERRUN = 10;
   localparam int BIT_BREAK   = 11;

   localparam logic [DATA_W-1:0] CODE_FRAMING = 8'd0;
   localparam logic [DATA_W-1:0] CODE_OVERRUN = 8'd1;
   localparam logic [DATA_W-1:0] CODE_PARITY  = 8'd2;
   localparam logic [DATA_W-1:0] CODE_BREAK   = 8'd3;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   localparam logic FUNC_RECEIVE = 1'b0;
   localparam logic FUNC_POP     = 1'b1;

   localparam logic [CSR_W-1:0] RING_SIZE_RESET = 9'd256;

   localparam int NUM_BANKS = 3;
   localparam int MAX_EVENTS = 3;

   typedef logic [1:0] bank_type;

   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] value;
   } event_type;

   typedef struct packed {
      logic [1:0]                 count;
      event_type [MAX_EVENTS-1:0] ev;
   } ev_list_type;

   // sum modulo three of two bank numbers
   function automatic bank_type bank_add(bank_type a, bank_type b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

endpackage

### sv/uref_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// uref_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module uref_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/uref_classify.sv
`timescale 1ns / 1ps
// ============================================================================
// uref_classify
// Splits a receive word into its ordered list of events.
// ============================================================================
module uref_classify (
   input  logic [uref_pkg::RX_W-1:0] rx_word,
   output uref_pkg::ev_list_type     ev_list
);
   import uref_pkg::*;

   logic      cand_valid [4];
   event_type cand       [4];
   logic [1:0] n;
   logic      no_error;

   assign no_error = (rx_word[BIT_BREAK:BIT_FRAMING] == 4'b0000);

   always_comb begin
      cand_valid[0] = rx_word[BIT_OVERRUN];
      cand[0]       = '{kind: KIND_ERROR, value: CODE_OVERRUN};
      // break hides framing
      cand_valid[1] = rx_word[BIT_BREAK] | rx_word[BIT_FRAMING];
      cand[1]       = '{kind: KIND_ERROR,
                        value: rx_word[BIT_BREAK] ? CODE_BREAK : CODE_FRAMING};
      cand_valid[2] = rx_word[BIT_PARITY];
      cand[2]       = '{kind: KIND_ERROR, value: CODE_PARITY};
      cand_valid[3] = no_error;
      cand[3]       = '{kind: KIND_CHAR, value: rx_word[DATA_W-1:0]};

      ev_list = '0;
      n       = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_valid[i]) begin
            ev_list.ev[n] = cand[i];
            n             = n + 2'd1;
         end
      end
      ev_list.count = n;
   end

endmodule

### sv/uart_rx_status_event_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// uart_rx_status_event_fifo
// Event ring for UART receive words: pushes error and character events,
// returns the oldest event on a pop.
// ============================================================================
//  port group  direction  handshake              payload
//  req_        in         req_valid/req_ready    func, rx_word
//  rsp_        out        rsp_valid/rsp_ready    pop_valid, event_kind,
//                                                event_value, events_stored,
//                                                events_dropped
//  csr_        in         csr_wr_en              ring_size
//
//  One word accepted per cycle while no result is stalled; its result is shown in the next cycle.
//  Slots 0 and 1 are registers and every higher slot sits in RAM bank
//  (slot mod 3), so the up to three pushes of one receive word never share
//  a write port.
//  A stalled result holds, and a new word is taken in the cycle it leaves.
//  Reset clears the indices and sets ring_size to 256; the RAM is not cleared.
// ============================================================================
module uart_rx_status_event_fifo #(
   parameter int RING_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [uref_pkg::RX_W-1:0]          req_rx_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pop_valid,
   output logic                               rsp_event_kind,
   output logic [uref_pkg::DATA_W-1:0]        rsp_event_value,
   output logic [1:0]                         rsp_events_stored,
   output logic [1:0]                         rsp_events_dropped,
   input  logic                               csr_wr_en,
   input  logic [uref_pkg::CSR_W-1:0]         csr_wr_data
);
   import uref_pkg::*;

   localparam int IW = $clog2(RING_DEPTH);
   localparam int SW = (IW + 1 > CSR_W) ? IW + 1 : CSR_W;

   logic [CSR_W-1:0] ring_size_ff;
   logic [IW-1:0]    wr_idx_ff, wr_idx_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   bank_type         wr_bank_ff, wr_bank_in;
   bank_type         rd_bank_ff, rd_bank_in;
   event_type        slot0_ff, slot0_in;
   event_type        slot1_ff, slot1_in;

   logic             rsp_valid_ff;
   logic             pop_ok_ff;
   logic             low_sel_ff;
   event_type        low_ev_ff;
   bank_type         bank_sel_ff;
   logic [1:0]       stored_ff;
   logic [1:0]       dropped_ff;

   logic             accept, recv_acc, pop_acc, pop_ok, nonempty;
   logic [SW-1:0]    size_ext, eff_wide;
   logic [IW:0]      eff;
   logic [IW:0]      rd_nxt;
   logic [IW-1:0]    rd_wrapped;

   ev_list_type      ev_list;
   logic [IW-1:0]    wp;
   bank_type         wb;
   logic [IW:0]      nxt;
   logic             wrap, full, blocked;
   logic [1:0]       stored, dropped;
   logic             push_ok   [MAX_EVENTS];
   logic [IW-1:0]    push_addr [MAX_EVENTS];
   bank_type         push_bank [MAX_EVENTS];

   logic             bank_we    [NUM_BANKS];
   logic [IW-1:0]    bank_waddr [NUM_BANKS];
   event_type        bank_wdata [NUM_BANKS];
   event_type        bank_rdata [NUM_BANKS];
   event_type        sel_event;

   uref_classify u_classify (
      .rx_word (req_rx_word),
      .ev_list (ev_list)
   );

   // handshake
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign recv_acc  = accept && (req_func == FUNC_RECEIVE);
   assign pop_acc   = accept && (req_func == FUNC_POP);

   // effective ring size
   always_comb begin
      size_ext = SW'(ring_size_ff);
      if (size_ext < SW'(2)) begin
         eff_wide = SW'(2);
      end else if (size_ext > SW'(RING_DEPTH)) begin
         eff_wide = SW'(RING_DEPTH);
      end else begin
         eff_wide = size_ext;
      end
      eff = eff_wide[IW:0];
   end

   // push chain: a drop blocks the rest of the word
   always_comb begin
      wp      = wr_idx_ff;
      wb      = wr_bank_ff;
      blocked = 1'b0;
      stored  = '0;
      dropped = '0;
      nxt     = '0;
      wrap    = 1'b0;
      full    = 1'b0;
      for (int j = 0; j < MAX_EVENTS; j++) begin
         push_ok[j]   = 1'b0;
         push_addr[j] = wp;
         push_bank[j] = wb;
         if (2'(j) < ev_list.count) begin
            nxt  = (IW+1)'(wp) + (IW+1)'(1);
            wrap = (nxt >= eff);
            full = ((IW+1)'(rd_idx_ff) == nxt) || (wrap && (rd_idx_ff == '0));
            if (!blocked && !full) begin
               push_ok[j] = 1'b1;
               wp         = wrap ? '0 : nxt[IW-1:0];
               wb         = wrap ? '0 : bank_add(wb, 2'd1);
               stored     = stored + 2'd1;
            end else begin
               blocked = 1'b1;
               dropped = dropped + 2'd1;
            end
         end
      end
   end

   // slots above 1 go to bank (slot mod 3)
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_we[b]    = 1'b0;
         bank_waddr[b] = push_addr[0];
         bank_wdata[b] = ev_list.ev[0];
         for (int j = 0; j < MAX_EVENTS; j++) begin
            if (push_ok[j] && (push_addr[j] > IW'(1)) && (push_bank[j] == 2'(b))) begin
               bank_we[b]    = recv_acc;
               bank_waddr[b] = push_addr[j];
               bank_wdata[b] = ev_list.ev[j];
            end
         end
      end
   end

   // slots 0 and 1
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      for (int j = 0; j < MAX_EVENTS; j++) begin
         if (recv_acc && push_ok[j] && (push_addr[j] == '0)) begin
            slot0_in = ev_list.ev[j];
         end
         if (recv_acc && push_ok[j] && (push_addr[j] == IW'(1))) begin
            slot1_in = ev_list.ev[j];
         end
      end
   end

   // pop side
   assign nonempty   = (rd_idx_ff != wr_idx_ff);
   assign pop_ok     = pop_acc && nonempty;
   assign rd_nxt     = (IW+1)'(rd_idx_ff) + (IW+1)'(1);
   assign rd_wrapped = (rd_nxt >= eff) ? '0 : rd_nxt[IW-1:0];

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      wr_bank_in = wr_bank_ff;
      rd_idx_in  = rd_idx_ff;
      rd_bank_in = rd_bank_ff;
      if (recv_acc) begin
         wr_idx_in  = wp;
         wr_bank_in = wb;
      end
      if (pop_ok) begin
         rd_idx_in  = rd_wrapped;
         rd_bank_in = (rd_nxt >= eff) ? '0 : bank_add(rd_bank_ff, 2'd1);
      end
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      uref_ram #(
         .WIDTH ($bits(event_type)),
         .DEPTH (RING_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_waddr[b]),
         .wr_data (bank_wdata[b]),
         .rd_en   (accept),
         .rd_addr (rd_idx_ff),
         .rd_data (bank_rdata[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         wr_bank_ff   <= '0;
         rd_bank_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ring_size_ff <= csr_wr_data;
         end
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         wr_bank_ff <= wr_bank_in;
         rd_bank_ff <= rd_bank_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // low slots and result word
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (accept) begin
         pop_ok_ff   <= pop_ok;
         low_sel_ff  <= (rd_idx_ff < IW'(2));
         low_ev_ff   <= rd_idx_ff[0] ? slot1_ff : slot0_ff;
         bank_sel_ff <= rd_bank_ff;
         stored_ff   <= recv_acc ? stored  : 2'd0;
         dropped_ff  <= recv_acc ? dropped : 2'd0;
      end
   end

   always_comb begin
      if (low_sel_ff) begin
         sel_event = low_ev_ff;
      end else begin
         case (bank_sel_ff)
            2'd0:    sel_event = bank_rdata[0];
            2'd1:    sel_event = bank_rdata[1];
            default: sel_event = bank_rdata[2];
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pop_valid      = pop_ok_ff;
   assign rsp_event_kind     = pop_ok_ff & sel_event.kind;
   assign rsp_event_value    = pop_ok_ff ? sel_event.value : '0;
   assign rsp_events_stored  = stored_ff;
   assign rsp_events_dropped = dropped_ff;

endmodule

### sv/uref_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// uref_checker
// Port-level checks for the UART receive status event ring.
// ============================================================================
module uref_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_pop_valid,
   input logic                        rsp_event_kind,
   input logic [uref_pkg::DATA_W-1:0] rsp_event_value,
   input logic [1:0]                  rsp_events_stored,
   input logic [1:0]                  rsp_events_dropped
);
   import uref_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_valid)
         && $stable(rsp_event_kind) && $stable(rsp_event_value)
         && $stable(rsp_events_stored) && $stable(rsp_events_dropped))
      else $error("result word changed while stalled");

   a_pop_no_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_valid |-> rsp_events_stored == 2'd0
         && rsp_events_dropped == 2'd0)
      else $error("popped event carries push counts");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pop_valid |-> !rsp_event_kind && rsp_event_value == '0)
      else $error("event fields set without a popped event");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_valid && rsp_event_kind == KIND_ERROR
         |-> rsp_event_value <= CODE_BREAK)
      else $error("unknown error code popped");

   a_push_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_events_stored} + {1'b0, rsp_events_dropped})
         <= 3'd3)
      else $error("more than three events from one word");

endmodule

bind uart_rx_status_event_fifo uref_checker u_uref_checker (.*);
